[design/u8u16_pkg.sv]
// u8u16_pkg: widths, constants, result entry type and helpers for the utf-8 to utf-16 decoder
// depends on nothing; used by the channel interfaces and the top level
package u8u16_pkg;

	localparam int COUNT_BITS = 32;          // width of the saturating unit counter
	localparam int BYTE_W     = 8;
	localparam int UNIT_W     = 16;
	localparam int CNT_PORT_W = 32;
	localparam int CP_W       = 31;
	localparam int LEFT_W     = 3;

	localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

	localparam logic [UNIT_W-1:0] SURR_HI_BASE = 16'hD800;
	localparam logic [UNIT_W-1:0] SURR_LO_BASE = 16'hDC00;
	localparam logic [CP_W-1:0]   SUPP_BASE    = 31'h0001_0000;
	localparam logic [BYTE_W-1:0] CONT_TAG_MASK = 8'hC0;
	localparam logic [BYTE_W-1:0] CONT_TAG      = 8'h80;
	localparam logic [BYTE_W-1:0] CONT_BITS     = 8'h3F;

	// lead byte classes: sequence length, with codes for the dropped forms
	localparam logic [2:0] LEN_ASCII = 3'd0;
	localparam logic [2:0] LEN_STRAY = 3'd1;
	localparam logic [2:0] LEN_BAD   = 3'd7;

	typedef struct packed {
		logic [UNIT_W-1:0]     unit;
		logic                  term;
		logic [CNT_PORT_W-1:0] count;
		logic                  last;
	} result_t;

	// saturating add of one or two units
	function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
		input logic [1:0] k);
		logic [COUNT_BITS:0] s;
		s = {1'b0, a} + (COUNT_BITS+1)'(k);
		if (s > {1'b0, CountMax}) begin
			return CountMax;
		end
		return s[COUNT_BITS-1:0];
	endfunction

	// count of leading ones in a lead byte; LEN_BAD (7) for seven or more
	function automatic logic [2:0] lead_len(input logic [BYTE_W-1:0] b);
		logic [2:0] len;
		unique casez (b)
			8'b0???????: len = LEN_ASCII;
			8'b10??????: len = LEN_STRAY;
			8'b110?????: len = 3'd2;
			8'b1110????: len = 3'd3;
			8'b11110???: len = 3'd4;
			8'b111110??: len = 3'd5;
			8'b1111110?: len = 3'd6;
			default:     len = LEN_BAD;
		endcase
		return len;
	endfunction

endpackage

[design/u8u16_byte_if.sv]
// u8u16_byte_if: valid/ready channel carrying one utf-8 byte per beat
// depends on u8u16_pkg for the byte width
interface u8u16_byte_if;
	logic                          valid;
	logic                          ready;
	logic [u8u16_pkg::BYTE_W-1:0]  in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

[design/u8u16_unit_if.sv]
// u8u16_unit_if: valid/ready channel carrying one utf-16 result per beat
// depends on u8u16_pkg for field widths
interface u8u16_unit_if;
	logic                              valid;
	logic                              ready;
	logic [u8u16_pkg::UNIT_W-1:0]      out_unit;
	logic                              is_terminator;
	logic [u8u16_pkg::CNT_PORT_W-1:0]  unit_count;
	logic                              run_last;

	modport source (output valid, output out_unit, output is_terminator, output unit_count,
		output run_last, input ready);
	modport sink   (input valid, input out_unit, input is_terminator, input unit_count,
		input run_last, output ready);
endinterface

[design/utf8_to_utf16_decoder.sv]
// utf8_to_utf16_decoder: streaming utf-8 (legacy 1..6 byte forms) to utf-16 transcoder
// depends on u8u16_pkg, u8u16_byte_if and u8u16_unit_if
//
//   channel  dir  beat                                        results per beat
//   utf8     in   in_byte                                     -
//   utf16    out  out_unit, is_terminator, unit_count, run_last  0, 1 or 2 per byte
//
// one byte per cycle while utf8 is not held off: decode state is updated and results are written to a
// three-entry result register in the cycle a byte is accepted
// a surrogate pair takes two output beats; utf8 is held off only when fewer
// than two result entries would be free after this cycle's output beat
// arst_n clears decode state, the unit counter and the result entry count; the entries are not reset
module utf8_to_utf16_decoder (
	input  logic                clk,
	input  logic                arst_n,
	u8u16_byte_if.sink          utf8,
	u8u16_unit_if.source        utf16
);

	localparam int DEPTH = 3;

	logic [u8u16_pkg::LEFT_W-1:0]     bytes_left_q;
	logic [u8u16_pkg::CP_W-1:0]       code_accum_q;
	logic                             seq_bad_q;
	logic [u8u16_pkg::COUNT_BITS-1:0] units_written_q;

	logic [u8u16_pkg::LEFT_W-1:0]     bytes_left_d;
	logic [u8u16_pkg::CP_W-1:0]       code_accum_d;
	logic                             seq_bad_d;
	logic [u8u16_pkg::COUNT_BITS-1:0] units_written_d;

	u8u16_pkg::result_t ent_q [DEPTH];
	u8u16_pkg::result_t ent_d [DEPTH];
	logic [1:0]         cnt_q;
	logic [1:0]         cnt_d;
	logic [1:0]         base;

	u8u16_pkg::result_t res0, res1;
	logic               push0, push1;
	logic               accept, pop;

	logic [u8u16_pkg::BYTE_W-1:0] b;
	logic [2:0]                   len;
	logic [u8u16_pkg::CP_W-1:0]   acc_next;
	logic [u8u16_pkg::CP_W-1:0]   cp;
	logic [u8u16_pkg::CP_W-1:0]   diff;
	logic                         emit;
	logic                         is_cont;

	assign b       = utf8.in_byte;
	assign pop     = (cnt_q != 2'd0) && utf16.ready;
	assign utf8.ready = (cnt_q < 2'd2) || ((cnt_q == 2'd2) && utf16.ready);
	assign accept  = utf8.valid && utf8.ready;
	assign len     = u8u16_pkg::lead_len(b);
	assign is_cont = (b & u8u16_pkg::CONT_TAG_MASK) == u8u16_pkg::CONT_TAG;
	assign acc_next = {code_accum_q[u8u16_pkg::CP_W-7:0], b[5:0]};
	assign diff    = cp - u8u16_pkg::SUPP_BASE;

	// decode one byte
	always_comb begin
		bytes_left_d    = bytes_left_q;
		code_accum_d    = code_accum_q;
		seq_bad_d       = seq_bad_q;
		units_written_d = units_written_q;
		emit            = 1'b0;
		cp              = '0;
		push0           = 1'b0;
		push1           = 1'b0;
		res0            = '0;
		res1            = '0;
		priority if (b == '0) begin
			// end of string, partial sequence dropped
			push0      = 1'b1;
			res0.term  = 1'b1;
			res0.count = u8u16_pkg::CNT_PORT_W'(u8u16_pkg::sat_add(units_written_q, 2'd1));
			res0.last  = 1'b1;
			bytes_left_d    = '0;
			code_accum_d    = '0;
			seq_bad_d       = 1'b0;
			units_written_d = '0;
		end else if (bytes_left_q != '0) begin
			bytes_left_d = bytes_left_q - 3'd1;
			if (is_cont) begin
				code_accum_d = acc_next;
			end else begin
				seq_bad_d = 1'b1;
			end
			if (bytes_left_q == 3'd1) begin
				emit         = !seq_bad_d;
				cp           = code_accum_d;
				code_accum_d = '0;
				seq_bad_d    = 1'b0;
			end
		end else begin
			unique case (len)
				u8u16_pkg::LEN_ASCII: begin
					emit = 1'b1;
					cp   = u8u16_pkg::CP_W'(b);
				end
				u8u16_pkg::LEN_STRAY, u8u16_pkg::LEN_BAD: begin
				end
				default: begin
					code_accum_d = u8u16_pkg::CP_W'(b & (8'hFF >> (4'(len) + 4'd1)));
					bytes_left_d = len - 3'd1;
					seq_bad_d    = 1'b0;
				end
			endcase
		end
		if (emit) begin
			push0 = 1'b1;
			if (cp[u8u16_pkg::CP_W-1:16] == '0) begin
				res0.unit = cp[15:0];
				res0.last = 1'b1;
				units_written_d = u8u16_pkg::sat_add(units_written_q, 2'd1);
			end else begin
				push1     = 1'b1;
				res0.unit = u8u16_pkg::SURR_HI_BASE | {6'd0, diff[19:10]};
				res1.unit = u8u16_pkg::SURR_LO_BASE | {6'd0, diff[9:0]};
				res1.last = 1'b1;
				units_written_d = u8u16_pkg::sat_add(units_written_q, 2'd2);
			end
		end
	end

	// result register: entry 0 is presented, new results append behind the rest
	always_comb begin
		base  = cnt_q - {1'b0, pop};
		cnt_d = base;
		for (int i = 0; i < DEPTH; i++) begin
			if (pop && (i < DEPTH - 1)) begin
				ent_d[i] = ent_q[(i + 1) % DEPTH];
			end else begin
				ent_d[i] = ent_q[i];
			end
			if (accept && push0 && (base == 2'(i))) begin
				ent_d[i] = res0;
			end
			if (accept && push1 && ((base + 2'd1) == 2'(i))) begin
				ent_d[i] = res1;
			end
		end
		if (accept) begin
			cnt_d = base + {1'b0, push0} + {1'b0, push1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q    <= '0;
			code_accum_q    <= '0;
			seq_bad_q       <= 1'b0;
			units_written_q <= '0;
			cnt_q           <= '0;
		end else begin
			cnt_q <= cnt_d;
			if (accept) begin
				bytes_left_q    <= bytes_left_d;
				code_accum_q    <= code_accum_d;
				seq_bad_q       <= seq_bad_d;
				units_written_q <= units_written_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			ent_q[i] <= ent_d[i];
		end
	end

	assign utf16.valid         = cnt_q != 2'd0;
	assign utf16.out_unit      = ent_q[0].unit;
	assign utf16.is_terminator = ent_q[0].term;
	assign utf16.unit_count    = ent_q[0].count;
	assign utf16.run_last      = ent_q[0].last;

endmodule
